// ===== src/hbd_pkg.sv =====
`default_nettype none

package hbd_pkg;

    // item codes
    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_DECODE = 1'b1
    } opcode_t;

    // node numbering
    localparam logic [8:0] END_LEAF   = 9'd256;
    localparam logic [9:0] FIRST_NODE = 10'd257;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ROOT_NODE = 1'b0;

    // table entry layout: left child over right child
    localparam int CHILD_W = 9;
    localparam int ENTRY_W = 2 * CHILD_W;

    typedef struct packed {
        opcode_t    opcode;
        logic [9:0] node_index;
        logic [8:0] left_child;
        logic [8:0] right_child;
        logic       code_bit;
    } in_item_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_stream;
    } out_item_t;

endpackage

`default_nettype wire

// ===== src/hbd_ram.sv =====
`default_nettype none

module hbd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/hbd_result_fifo.sv =====
`default_nettype none

module hbd_result_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire hbd_pkg::out_item_t push_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output hbd_pkg::out_item_t     m_data,
    output logic [1:0]             level
);

    import hbd_pkg::*;

    localparam int DEPTH = 3;
    localparam logic [1:0] LAST_PTR = 2'(DEPTH - 1);

    out_item_t  slot_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign m_valid = (count_reg != 2'd0);
    assign m_data  = slot_reg[rd_ptr_reg];
    assign level   = count_reg;
    assign pop     = m_valid && m_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? 2'd0 : wr_ptr_reg + 2'd1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? 2'd0 : rd_ptr_reg + 2'd1;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== src/huffman_tree_bit_decoder.sv =====
// Bit-serial Huffman decoder walking a child table held in one synchronous RAM.
// Input channel s_*: load items (opcode 0) write the children of internal node
// node_index; decode items (opcode 1) carry one code bit. Result channel m_*:
// one decoded byte, or the end-of-stream marker, per completed code word.
// Configuration: APB register root_node at byte address 0 restarts the walk.
// Throughput: one item per cycle while s_ready is high. The next-node loop is one
// RAM read: the read address for a bit is formed from the previous bit's RAM data
// in the same cycle it leaves the RAM, so consecutive bits issue on consecutive cycles.
// Result path: table read register, then the output buffer, which drives m_valid.
// Stalls: results queue in a three-entry output buffer; s_ready drops once the
// buffered results plus a decode item still in flight would fill that buffer.
// Reset: walk at node 257, end flag clear, output buffer empty. Table contents
// are undefined until loaded; there is no clearing pass.
// After the end-of-stream marker, decode bits are dropped until a load item
// or a root_node write.
`default_nettype none

module huffman_tree_bit_decoder #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire hbd_pkg::in_item_t             s_data,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output hbd_pkg::out_item_t                 m_data,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hbd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [hbd_pkg::PDATA_W-1:0]   pwdata,
    output logic      [hbd_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    import hbd_pkg::*;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam logic [9:0] DEPTH_10 = 10'(TABLE_DEPTH);

    logic [9:0]        root_reg, root_next;
    logic [9:0]        cur_reg, cur_next, cur_resolved;
    logic              fin_reg, fin_next, fin_resolved;
    logic              s1_valid_reg;
    opcode_t           s1_op_reg;
    logic              s1_bit_reg;
    logic              s1_hit_reg;
    logic              s_xfer;
    logic              cfg_write;
    logic [ENTRY_W-1:0] entry;
    logic [8:0]        child;
    logic              res_valid;
    out_item_t         res_item;
    logic [1:0]        fifo_level;
    logic              s1_pend;
    logic [9:0]        wr_diff, rd_diff;
    logic              wr_hit, rd_hit;
    logic              tbl_we;

    function automatic logic in_table(input logic [9:0] node);
        logic [9:0] diff;
        diff = node - FIRST_NODE;
        return (node >= FIRST_NODE) && (diff < DEPTH_10);
    endfunction

    // handshakes
    assign s1_pend   = s1_valid_reg && (s1_op_reg == OP_DECODE);
    assign s_ready   = ({1'b0, fifo_level} + {2'b0, s1_pend}) <= 3'd2;
    assign s_xfer    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_ROOT_NODE);

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ROOT_NODE) ? {{(PDATA_W-10){1'b0}}, root_reg}
                                                : '0;

    // resolve the item in flight against the table word read for it
    assign child = s1_bit_reg ? entry[CHILD_W-1:0] : entry[ENTRY_W-1:CHILD_W];

    always_comb begin
        cur_resolved = cur_reg;
        fin_resolved = fin_reg;
        res_valid    = 1'b0;
        res_item     = '0;
        if (s1_valid_reg) begin
            if (s1_op_reg == OP_LOAD) begin
                cur_resolved = root_reg;
                fin_resolved = 1'b0;
            end else if (!fin_reg) begin
                if (!s1_hit_reg) begin
                    cur_resolved = root_reg;
                end else if (child == END_LEAF) begin
                    cur_resolved           = root_reg;
                    fin_resolved           = 1'b1;
                    res_valid              = 1'b1;
                    res_item.end_of_stream = 1'b1;
                end else if (!child[8]) begin
                    cur_resolved    = root_reg;
                    res_valid       = 1'b1;
                    res_item.symbol = child[7:0];
                end else begin
                    cur_resolved = {1'b0, child};
                end
            end
        end
    end

    // walk state, root register writes restart it
    always_comb begin
        root_next = root_reg;
        cur_next  = cur_resolved;
        fin_next  = fin_resolved;
        if (cfg_write) begin
            root_next = pwdata[9:0];
            cur_next  = pwdata[9:0];
            fin_next  = 1'b0;
        end
    end

    // table addressing: write from load items, read for the node the next bit walks from
    assign wr_diff = s_data.node_index - FIRST_NODE;
    assign wr_hit  = in_table(s_data.node_index);
    assign tbl_we  = s_xfer && (s_data.opcode == OP_LOAD) && wr_hit;
    assign rd_diff = cur_resolved - FIRST_NODE;
    assign rd_hit  = in_table(cur_resolved);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg     <= FIRST_NODE;
            cur_reg      <= FIRST_NODE;
            fin_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else begin
            root_reg     <= root_next;
            cur_reg      <= cur_next;
            fin_reg      <= fin_next;
            s1_valid_reg <= s_xfer;
        end
    end

    // item in flight
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_op_reg  <= s_data.opcode;
            s1_bit_reg <= s_data.code_bit;
            s1_hit_reg <= rd_hit;
        end
    end

    hbd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_child_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (wr_diff[SLOT_W-1:0]),
        .wdata ({s_data.left_child, s_data.right_child}),
        .raddr (rd_diff[SLOT_W-1:0]),
        .rdata (entry)
    );

    hbd_result_fifo u_result_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_item (res_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .level     (fifo_level)
    );

endmodule

`default_nettype wire
